FILE: hdl/ssr_pkg.sv
// Shared types, constants and the case-folding helper for the search and replace block.
// No dependencies; used by every other file in hdl/.
package ssr_pkg;

  localparam int CNT_W = 4;   // results per request, 0..8
  localparam int TOT_W = 16;  // saturating replacement count

  typedef enum logic [2:0] {
    REG_PATTERN_BYTES      = 3'd0,
    REG_PATTERN_LENGTH     = 3'd1,
    REG_REPLACEMENT_BYTES  = 3'd2,
    REG_REPLACEMENT_LENGTH = 3'd3,
    REG_EXACT_CASE         = 3'd4
  } cfg_reg_t;

  // Control handed to each window cell.
  typedef struct packed {
    logic en;     // a request is taken this cycle
    logic load;   // new byte lands in this cell
    logic shift;  // take the right-hand neighbour's byte
    logic fold;   // compare with letters folded to upper case
  } ssr_cell_ctrl_t;

  // Description of one request's results, loaded into the output buffer.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             marker;  // empty end-of-text result
    logic             eot;
    logic [TOT_W-1:0] total;
  } ssr_step_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c, input logic fold_en);
    logic [7:0] r;
    r = c;
    if (fold_en && c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: hdl/ssr_cell.sv
// One lookahead window cell: holds a byte, compares it with its pattern byte.
// Depends on ssr_pkg.
module ssr_cell
  import ssr_pkg::*;
(
  input  logic           clk,
  input  ssr_cell_ctrl_t ctrl,
  input  logic [7:0]     new_byte,
  input  logic [7:0]     right_view,
  input  logic [7:0]     pat_byte,
  output logic [7:0]     view,
  output logic           match
);

  logic [7:0] stored;

  // view is the window content after this request's byte is inserted
  assign view  = ctrl.load ? new_byte : stored;
  assign match = (fold_upper(view, ctrl.fold) == fold_upper(pat_byte, ctrl.fold));

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      stored <= ctrl.shift ? right_view : view;
    end
  end

endmodule

FILE: hdl/ssr_out_buf.sv
// Output lane buffer: takes all results of one request, drains one per cycle while result_stall is low.
// Depends on ssr_pkg.
module ssr_out_buf
  import ssr_pkg::*;
#(
  parameter int NL = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ssr_step_t        step,
  input  logic [7:0]       lane_in [NL],
  output logic [CNT_W-1:0] count,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             last_of_step,
  output logic             end_of_output,
  output logic [TOT_W-1:0] match_total
);

  logic [7:0]       lanes [NL];
  logic             marker;
  logic             eot;
  logic [TOT_W-1:0] total;
  logic             pop;

  assign pop = (count != '0) && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= step.count;
    end else if (pop) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lanes  <= lane_in;
      marker <= step.marker;
      eot    <= step.eot;
      total  <= step.total;
    end else if (pop) begin
      for (int k = 0; k < NL - 1; k++) begin
        lanes[k] <= lanes[k + 1];
      end
      lanes[NL - 1] <= 8'h00;
    end
  end

  assign result_valid  = (count != '0);
  assign out_byte      = marker ? 8'h00 : lanes[0];
  assign byte_valid    = !marker;
  assign last_of_step  = (count == CNT_W'(1));
  assign end_of_output = (count == CNT_W'(1)) && eot;
  assign match_total   = total;

endmodule

FILE: hdl/stream_search_and_replace_top.sv
// Streaming search and replace, top level.
// Timing: results are registered; the first result of a request appears in the cycle after it is taken.
// Throughput: one request a cycle while each gives at most one result and result_stall is low; a
//   request giving several results holds the input side until its lanes drain to the last one.
// Reset: synchronous, active high; registers that have reset values return to them at once,
//   no clearing pass.
module stream_search_and_replace_top
  import ssr_pkg::*;
#(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic        clk,
  input  logic        rst,
  // text requests
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_input,
  // result requests
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last_of_step,
  output logic        end_of_output,
  output logic [15:0] match_total,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NL = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int FW = $clog2(MAX_PATTERN + 1);

  // ---------------------------------------------------------------- config registers
  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;
  logic        exact_case;
  logic        cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= '0;
      replacement_length <= '0;
      exact_case         <= 1'b1;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
        REG_EXACT_CASE:         exact_case         <= cfg_data[0];
        default: ; // indexes past the list are ignored
      endcase
    end
  end

  // Effective lengths: zero pattern acts as one, both clamp to MAX_PATTERN and MAX_REPLACEMENT.
  logic [3:0]       pat_len4;
  logic [FW-1:0]    len;
  logic [CNT_W-1:0] rep_len;

  assign pat_len4 = (pattern_length == 4'd0) ? 4'd1 :
                    (pattern_length > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : pattern_length;
  assign len      = FW'(pat_len4);
  assign rep_len  = (replacement_length > 4'(MAX_REPLACEMENT)) ?
                    CNT_W'(MAX_REPLACEMENT) : CNT_W'(replacement_length);

  // ---------------------------------------------------------------- window control
  logic          text_fire;
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_ins;   // fill after this request's byte is inserted
  logic          has_room;
  logic          full;
  logic          hit_all;
  logic          hit;
  logic [CNT_W-1:0] buf_count;

  assign text_fire = text_valid && !text_stall;
  assign has_room  = (fill < len);
  assign fill_ins  = has_room ? fill + FW'(1) : fill;
  assign full      = (fill_ins >= len);

  // Take a request only if the lanes will be empty by the next edge.
  assign text_stall = (buf_count > CNT_W'(1)) || ((buf_count == CNT_W'(1)) && result_stall);

  // ---------------------------------------------------------------- cell row
  // view_chain[i] is cell i's byte after insertion; the far end feeds zero.
  logic [7:0] view_chain [MAX_PATTERN + 1];
  logic       match [MAX_PATTERN];

  assign view_chain[MAX_PATTERN] = 8'h00;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    ssr_cell_ctrl_t ctrl;
    assign ctrl.en    = text_fire;
    assign ctrl.load  = has_room && (fill == FW'(i));
    assign ctrl.shift = full && !hit;   // oldest byte leaves, rest move one place down
    assign ctrl.fold  = !exact_case;

    ssr_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_byte   (text_byte),
      .right_view (view_chain[i + 1]),
      .pat_byte   (pattern_bytes[8*i +: 8]),
      .view       (view_chain[i]),
      .match      (match[i])
    );
  end

  // only cells below the pattern length take part
  always_comb begin
    hit_all = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((FW'(i) < len) && !match[i]) begin
        hit_all = 1'b0;
      end
    end
  end

  assign hit = full && hit_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cfg_fire && (cfg_index == REG_PATTERN_LENGTH)) begin
      fill <= '0;   // new length drops the held bytes
    end else if (text_fire) begin
      if (hit || end_of_input) begin
        fill <= '0;
      end else if (full) begin
        fill <= fill_ins - FW'(1);
      end else begin
        fill <= fill_ins;
      end
    end
  end

  // ---------------------------------------------------------------- step results
  // On a hit the lanes carry the replacement; otherwise the window in order, of
  // which the oldest byte alone goes out mid-text once full and all of it at end of text.
  logic [7:0]       step_byte [NL];
  logic [CNT_W-1:0] step_n;
  logic [TOT_W-1:0] match_counter;
  logic [TOT_W-1:0] count_step;
  ssr_step_t        step;

  for (genvar k = 0; k < NL; k++) begin : g_lane
    logic [7:0] win_byte;
    if (k < MAX_PATTERN) begin : g_win
      assign win_byte = view_chain[k];
    end else begin : g_pad
      assign win_byte = 8'h00;
    end
    assign step_byte[k] = hit ? replacement_bytes[8*k +: 8] : win_byte;
  end

  always_comb begin
    if (hit) begin
      step_n = rep_len;
    end else if (end_of_input) begin
      step_n = CNT_W'(fill_ins);
    end else if (full) begin
      step_n = CNT_W'(1);
    end else begin
      step_n = '0;
    end
  end

  assign count_step = (hit && (match_counter != {TOT_W{1'b1}})) ?
                      match_counter + TOT_W'(1) : match_counter;

  assign step.marker = end_of_input && (step_n == '0);
  assign step.count  = step.marker ? CNT_W'(1) : step_n;
  assign step.eot    = end_of_input;
  assign step.total  = count_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_counter <= '0;
    end else if (text_fire) begin
      match_counter <= end_of_input ? '0 : count_step;
    end
  end

  // ---------------------------------------------------------------- output lanes
  ssr_out_buf #(
    .NL (NL)
  ) u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .load          (text_fire),
    .step          (step),
    .lane_in       (step_byte),
    .count         (buf_count),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last_of_step  (last_of_step),
    .end_of_output (end_of_output),
    .match_total   (match_total)
  );

  // ---------------------------------------------------------------- assertions
  a_lanes_bound: assert property (@(posedge clk) disable iff (rst)
    buf_count <= CNT_W'(NL))
    else $error("output lane count above lane depth");

  a_eot_empties: assert property (@(posedge clk) disable iff (rst)
    text_fire && end_of_input |=> fill == '0)
    else $error("window not empty after end of text");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !byte_valid |-> end_of_output && last_of_step)
    else $error("empty marker away from end of text");

endmodule
